// ----- rtl/fps_pkg.sv -----
// Shared constants, codes and types of the Fenwick prefix-sum store.
`default_nettype none

package fps_pkg;

    localparam int ROWS    = 8;
    localparam int SIZE    = 512;

    localparam int MODE_W  = 2;
    localparam int ROW_W   = 3;
    localparam int POS_W   = 10;
    localparam int DELTA_W = 16;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 10;

    localparam int POS_AW  = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W  = ROW_AW + POS_AW;
    localparam int LIM_W   = ($clog2(SIZE + 1) > CFG_W) ? $clog2(SIZE + 1) : CFG_W;
    localparam int IDX_W   = LIM_W + 1;

    localparam logic [CFG_W-1:0] ACTIVE_SIZE_RST = CFG_W'(512);

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_CLR,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic step_down;
        logic add_acc;
    } t_alu_ctl;

endpackage

`default_nettype wire

// ----- rtl/fps_ram.sv -----
// Single-port RAM with registered read data.
`default_nettype none

module fps_ram #(
    parameter int DW = 32,
    parameter int AW = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1 << AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/fps_alu.sv -----
// Shared node adder and lowest-set-bit index stepper of the tree walk.
`default_nettype none

module fps_alu (
    input  wire fps_pkg::t_alu_ctl                 i_ctl,
    input  wire logic [fps_pkg::DATA_W-1:0]        i_mem_data,
    input  wire logic [fps_pkg::DATA_W-1:0]        i_acc,
    input  wire logic [fps_pkg::DATA_W-1:0]        i_delta,
    input  wire logic [fps_pkg::IDX_W-1:0]         i_idx,
    output logic      [fps_pkg::DATA_W-1:0]        o_sum,
    output logic      [fps_pkg::IDX_W-1:0]         o_idx_next
);

    logic [fps_pkg::IDX_W-1:0] w_low;

    // isolate the lowest set bit of the index
    assign w_low = i_idx & (~i_idx + fps_pkg::IDX_W'(1));

    assign o_sum      = i_mem_data + (i_ctl.add_acc ? i_acc : i_delta);
    assign o_idx_next = i_ctl.step_down ? (i_idx - w_low) : (i_idx + w_low);

endmodule

`default_nettype wire

// ----- rtl/fenwick_prefix_sum_store.sv -----
// Top level of the Fenwick prefix-sum store: sequencer, config and result register.
`default_nettype none

// A bank of ROWS binary indexed trees of SIZE 32-bit nodes, held in one single-port
// RAM. Each request is handled alone; o_ready drops from accept until the result is
// loaded into the output register. Add and query take one RAM read per visited node,
// then the write-back or accumulate through the shared adder, plus the steps for
// accept, the end-of-walk check and result load. Clear of a row writes one node per
// cycle, all 2^ceil(log2(SIZE)) nodes of the row. After reset a clearing pass writes
// zero to all ROWS*2^ceil(log2(SIZE)) = 4096 words, one per cycle, before the first
// request is taken; config writes are taken at any time.
// A result is 0 for every mode but query, and for a row at or beyond ROWS.
module fenwick_prefix_sum_store (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [fps_pkg::MODE_W-1:0]           i_mode,
    input  wire logic [fps_pkg::ROW_W-1:0]            i_row,
    input  wire logic [fps_pkg::POS_W-1:0]            i_position,
    input  wire logic signed [fps_pkg::DELTA_W-1:0]   i_delta,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [fps_pkg::DATA_W-1:0]         o_prefix_sum,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [fps_pkg::CFG_W-1:0]            i_cfg_active_size
);

    fps_pkg::t_state                  r_state, n_state;
    fps_pkg::t_mode                   r_mode;
    logic [fps_pkg::ROW_AW-1:0]       r_row;
    logic [fps_pkg::DATA_W-1:0]       r_delta;
    logic [fps_pkg::IDX_W-1:0]        r_idx, n_idx;
    logic [fps_pkg::DATA_W-1:0]       r_acc, n_acc;
    logic [fps_pkg::ADDR_W-1:0]       r_cnt, n_cnt;
    logic [fps_pkg::CFG_W-1:0]        r_active_size;
    logic                             r_out_valid;
    logic [fps_pkg::DATA_W-1:0]       r_out_data;

    logic                             w_accept;
    logic                             w_row_ok;
    logic                             w_load;
    logic [fps_pkg::LIM_W-1:0]        w_lim;
    logic [fps_pkg::LIM_W-1:0]        w_pos;
    logic [fps_pkg::IDX_W-1:0]        w_idx_m1;
    logic [fps_pkg::ADDR_W-1:0]       w_node_addr;
    logic                             w_ram_we;
    logic [fps_pkg::ADDR_W-1:0]       w_ram_addr;
    logic [fps_pkg::DATA_W-1:0]       w_ram_wdata;
    logic [fps_pkg::DATA_W-1:0]       w_ram_rdata;
    fps_pkg::t_alu_ctl                w_alu_ctl;
    logic [fps_pkg::DATA_W-1:0]       w_alu_sum;
    logic [fps_pkg::IDX_W-1:0]        w_alu_idx;

    assign o_ready      = (r_state == fps_pkg::ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_out_valid;
    assign o_prefix_sum = r_out_data;

    assign w_accept = i_valid && o_ready;
    assign w_row_ok = (32'(i_row) < fps_pkg::ROWS);
    assign w_load   = (r_state == fps_pkg::ST_FIN) && (!r_out_valid || i_ready);

    // saturate the active size to the tree size
    assign w_lim = (fps_pkg::LIM_W'(r_active_size) > fps_pkg::LIM_W'(fps_pkg::SIZE)) ?
                   fps_pkg::LIM_W'(fps_pkg::SIZE) : fps_pkg::LIM_W'(r_active_size);
    assign w_pos = (fps_pkg::LIM_W'(i_position) > w_lim) ? w_lim
                                                          : fps_pkg::LIM_W'(i_position);

    assign w_idx_m1    = r_idx - fps_pkg::IDX_W'(1);
    assign w_node_addr = {r_row, w_idx_m1[fps_pkg::POS_AW-1:0]};

    fps_ram #(
        .DW (fps_pkg::DATA_W),
        .AW (fps_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    fps_alu u_alu (
        .i_ctl      (w_alu_ctl),
        .i_mem_data (w_ram_rdata),
        .i_acc      (r_acc),
        .i_delta    (r_delta),
        .i_idx      (r_idx),
        .o_sum      (w_alu_sum),
        .o_idx_next (w_alu_idx)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fps_pkg::ST_INIT: begin
                if (r_cnt == '1) begin
                    n_state = fps_pkg::ST_IDLE;
                end
            end
            fps_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (!w_row_ok) begin
                        n_state = fps_pkg::ST_FIN;
                    end else begin
                        unique case (fps_pkg::t_mode'(i_mode))
                            fps_pkg::MODE_ADD: begin
                                n_state = (i_position == '0) ? fps_pkg::ST_FIN
                                                             : fps_pkg::ST_ADD_RD;
                            end
                            fps_pkg::MODE_QUERY: n_state = fps_pkg::ST_SUM_RD;
                            fps_pkg::MODE_CLEAR: n_state = fps_pkg::ST_CLR;
                            default:             n_state = fps_pkg::ST_FIN;
                        endcase
                    end
                end
            end
            fps_pkg::ST_ADD_RD: begin
                n_state = (r_idx <= fps_pkg::IDX_W'(w_lim)) ? fps_pkg::ST_ADD_WR
                                                            : fps_pkg::ST_FIN;
            end
            fps_pkg::ST_ADD_WR:  n_state = fps_pkg::ST_ADD_RD;
            fps_pkg::ST_SUM_RD: begin
                n_state = (r_idx != '0) ? fps_pkg::ST_SUM_ACC : fps_pkg::ST_FIN;
            end
            fps_pkg::ST_SUM_ACC: n_state = fps_pkg::ST_SUM_RD;
            fps_pkg::ST_CLR: begin
                if (r_cnt[fps_pkg::POS_AW-1:0] == '1) begin
                    n_state = fps_pkg::ST_FIN;
                end
            end
            fps_pkg::ST_FIN: begin
                if (w_load) begin
                    n_state = fps_pkg::ST_IDLE;
                end
            end
            default: n_state = fps_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        w_ram_we    = 1'b0;
        w_ram_addr  = w_node_addr;
        w_ram_wdata = w_alu_sum;
        w_alu_ctl   = '{step_down: 1'b0, add_acc: 1'b0};
        unique case (r_state)
            fps_pkg::ST_INIT: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_cnt;
                w_ram_wdata = '0;
                n_cnt       = r_cnt + fps_pkg::ADDR_W'(1);
            end
            fps_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_acc = '0;
                    n_cnt = '0;
                    n_idx = (fps_pkg::t_mode'(i_mode) == fps_pkg::MODE_QUERY) ?
                            fps_pkg::IDX_W'(w_pos) : fps_pkg::IDX_W'(i_position);
                end
            end
            fps_pkg::ST_ADD_WR: begin
                // node already read: write back node + delta, step up
                w_ram_we = 1'b1;
                n_idx    = w_alu_idx;
            end
            fps_pkg::ST_SUM_ACC: begin
                w_alu_ctl = '{step_down: 1'b1, add_acc: 1'b1};
                n_acc     = w_alu_sum;
                n_idx     = w_alu_idx;
            end
            fps_pkg::ST_CLR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = {r_row, r_cnt[fps_pkg::POS_AW-1:0]};
                w_ram_wdata = '0;
                n_cnt       = r_cnt + fps_pkg::ADDR_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fps_pkg::ST_INIT;
            r_cnt         <= '0;
            r_active_size <= fps_pkg::ACTIVE_SIZE_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_size <= i_cfg_active_size;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_acc <= n_acc;
        if (w_accept) begin
            r_mode  <= fps_pkg::t_mode'(i_mode);
            r_row   <= fps_pkg::ROW_AW'(i_row);
            r_delta <= fps_pkg::DATA_W'(i_delta);
        end
        if (w_load) begin
            // only a query leaves a nonzero accumulator
            r_out_data <= (r_mode == fps_pkg::MODE_QUERY) ? r_acc : '0;
        end
    end

    a_add_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fps_pkg::ST_ADD_WR) |->
            (r_idx != '0) && (r_idx <= fps_pkg::IDX_W'(w_lim)))
        else $error("add walk writes a node outside the active tree");

    a_sum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fps_pkg::ST_SUM_ACC) |-> (r_idx != '0))
        else $error("query walk accumulates at index zero");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fps_pkg::ST_FIN && (!r_out_valid || i_ready)) |=>
            (r_out_valid && r_state == fps_pkg::ST_IDLE))
        else $error("finished request not loaded into output register");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after accepting a request");

endmodule

`default_nettype wire
